// File: hw/rtl/line_position_pid_drive_unit_defines.svh
// Assertion macros for the line position PID drive unit.
`ifndef LINE_POSITION_PID_DRIVE_UNIT_DEFINES_SVH
`define LINE_POSITION_PID_DRIVE_UNIT_DEFINES_SVH

// Check a consequence in the same cycle as its trigger.
`define LPD_CHECK(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Check a consequence in the cycle after its trigger.
`define LPD_CHECK_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: hw/rtl/lpd_pkg.sv
package lpd_pkg;

  // Fixed point format
  localparam int FRAC_BITS  = 8;

  // Field widths
  localparam int SENS_W     = 12;
  localparam int GAIN_W     = 16;
  localparam int DCFG_W     = 7;
  localparam int OUT_W      = 16;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;

  // Centroid widths: weighted sum, plain sum, magnitude times ten
  localparam int WSUM_W     = 15;
  localparam int SUM_W      = 14;
  localparam int ABS10_W    = 18;

  // Error path widths
  localparam int ERR_W      = FRAC_BITS + 6;
  localparam int DIFF_W     = FRAC_BITS + 7;
  localparam int Q_W        = FRAC_BITS + 5;
  localparam int DVD_W      = FRAC_BITS + ABS10_W;
  localparam int DIV_CNT_W  = $clog2(Q_W);

  // PID and duty widths
  localparam int PROD_W     = GAIN_W + 1 + DIFF_W;
  localparam int ACC_W      = PROD_W + 2;
  localparam int CORR_W     = ACC_W - FRAC_BITS + 1;
  localparam int DUTY_W     = CORR_W + 1;
  localparam int DOUT_W     = FRAC_BITS + DCFG_W;
  localparam int JUNC_W     = DOUT_W + 1;

  // Error constants
  localparam logic signed [ERR_W-1:0]  ERR_LOST = ERR_W'(25 << FRAC_BITS);
  localparam logic signed [DIFF_W-1:0] ESUM_HI  = DIFF_W'(30 << FRAC_BITS);
  localparam logic signed [DIFF_W-1:0] ESUM_LO  = -ESUM_HI;
  localparam int                       ESUM_LIM = 30 << FRAC_BITS;
  localparam logic [ACC_W-1:0]         RND_HALF = ACC_W'(1 << (FRAC_BITS - 1));

  // Register reset values
  localparam logic [DCFG_W-1:0] BASE_RST   = 7'd49;
  localparam logic [DCFG_W-1:0] MIN_RST    = 7'd39;
  localparam logic [DCFG_W-1:0] MAX_RST    = 7'd59;
  localparam logic [SENS_W-1:0] DARK_RST   = 12'd400;
  localparam logic [SENS_W-1:0] BRIGHT_RST = 12'd2000;

  typedef enum logic [2:0] {
    REG_PROP_GAIN     = 3'd0,
    REG_INTEGRAL_GAIN = 3'd1,
    REG_DERIV_GAIN    = 3'd2,
    REG_BASE_DUTY     = 3'd3,
    REG_MIN_DUTY      = 3'd4,
    REG_MAX_DUTY      = 3'd5,
    REG_DARK_LEVEL    = 3'd6,
    REG_BRIGHT_LEVEL  = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    MNV_STRAIGHT = 3'd0,
    MNV_JUNCTION = 3'd1,
    MNV_LEFT     = 3'd2,
    MNV_RIGHT    = 3'd3,
    MNV_DARK     = 3'd4,
    MNV_BLIND    = 3'd5
  } mnv_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_SCALE,
    ST_DIV,
    ST_ERR,
    ST_UPD,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_D,
    ST_ACC,
    ST_ROUND,
    ST_DUTY_L,
    ST_DUTY_R,
    ST_OUT
  } state_t;

endpackage

// File: hw/rtl/line_position_pid_drive_unit.sv
// An accepted scan steps through the sequencer to ST_OUT, which waits while out_stall
// holds a pending result. One scan at a time: in_stall is high from acceptance until the
// result is loaded into the output register.
// The sequence runs through the restoring divider (FRAC_BITS+5 steps) and three passes
// through the one multiplier. Synchronous reset clears the sequencer, the error
// history and the output valid, and loads the register defaults.
`include "line_position_pid_drive_unit_defines.svh"

module line_position_pid_drive_unit
  import lpd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // scan channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [SENS_W-1:0] sensor_a,
  input  logic [SENS_W-1:0] sensor_b,
  input  logic [SENS_W-1:0] sensor_c,
  input  logic [SENS_W-1:0] sensor_d,
  // drive channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [OUT_W-1:0]  left_duty,
  output logic [OUT_W-1:0]  right_duty,
  output logic              left_reverse,
  output logic              right_reverse,
  output logic [2:0]        manoeuvre,
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  state_t state, state_next;
  logic   out_load;

  // configuration registers
  logic [GAIN_W-1:0] prop_gain, integral_gain, deriv_gain;
  logic [DCFG_W-1:0] base_duty, min_duty, max_duty;
  logic [SENS_W-1:0] dark_level, bright_level;
  reg_idx_t          reg_idx;
  logic              cfg_wr;

  // scan and class
  logic [SENS_W-1:0] sa, sb, sc, sd;
  logic              lit, lrev, rrev;
  mnv_t              mnv;

  // centroid and divider
  logic signed [WSUM_W-1:0] wsum;
  logic [SUM_W-1:0]         sum;
  logic                     wneg;
  logic [SUM_W-1:0]         rem;
  logic [Q_W-1:0]           quo;
  logic [DIV_CNT_W-1:0]     div_cnt;

  // PID state and datapath
  logic signed [ERR_W-1:0]  err, last_error, esum;
  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [CORR_W-1:0] corr;
  logic [DOUT_W-1:0]        left_val, right_val;

  // combinational terms
  logic signed [WSUM_W-1:0] ea, eb, ec, ed, wsum_c;
  logic [SUM_W-1:0]         sum_c, absw;
  logic                     lit_c, lrev_c, rrev_c;
  logic                     hi_a, hi_b, hi_c, hi_d, lo_a, lo_b, lo_c, lo_d;
  mnv_t                     mnv_c;
  logic [ABS10_W-1:0]       abs10;
  logic [DVD_W-1:0]         dvd_c;
  logic [SUM_W:0]           shifted, trial;
  logic                     div_ge;
  logic signed [ERR_W-1:0]  qs, err_c;
  logic signed [DIFF_W-1:0] err_x, last_x, esum_x, esum_t, esum_c;
  logic [GAIN_W-1:0]        gain_sel;
  logic signed [DIFF_W-1:0] opnd;
  logic signed [PROD_W-1:0] prod_c;
  logic signed [ACC_W-1:0]  prod_x;
  logic [ACC_W-1:0]         acc_mag, acc_rnd;
  logic signed [CORR_W-1:0] corr_pos;
  logic signed [DUTY_W-1:0] base_s, lo_s, hi_s, corr_x, duty_v, duty_c1, duty_c2;
  logic [JUNC_W-1:0]        junc_l, junc_r;

  // register port: always ready, write on the access beat
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign cfg_wr  = psel & penable & pwrite;

  always_comb begin
    case (reg_idx)
      REG_PROP_GAIN:     prdata = DATA_W'(prop_gain);
      REG_INTEGRAL_GAIN: prdata = DATA_W'(integral_gain);
      REG_DERIV_GAIN:    prdata = DATA_W'(deriv_gain);
      REG_BASE_DUTY:     prdata = DATA_W'(base_duty);
      REG_MIN_DUTY:      prdata = DATA_W'(min_duty);
      REG_MAX_DUTY:      prdata = DATA_W'(max_duty);
      REG_DARK_LEVEL:    prdata = DATA_W'(dark_level);
      REG_BRIGHT_LEVEL:  prdata = DATA_W'(bright_level);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain     <= '0;
      integral_gain <= '0;
      deriv_gain    <= '0;
      base_duty     <= BASE_RST;
      min_duty      <= MIN_RST;
      max_duty      <= MAX_RST;
      dark_level    <= DARK_RST;
      bright_level  <= BRIGHT_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_PROP_GAIN:     prop_gain     <= pwdata[GAIN_W-1:0];
        REG_INTEGRAL_GAIN: integral_gain <= pwdata[GAIN_W-1:0];
        REG_DERIV_GAIN:    deriv_gain    <= pwdata[GAIN_W-1:0];
        REG_BASE_DUTY:     base_duty     <= pwdata[DCFG_W-1:0];
        REG_MIN_DUTY:      min_duty      <= pwdata[DCFG_W-1:0];
        REG_MAX_DUTY:      max_duty      <= pwdata[DCFG_W-1:0];
        REG_DARK_LEVEL:    dark_level    <= pwdata[SENS_W-1:0];
        REG_BRIGHT_LEVEL:  bright_level  <= pwdata[SENS_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = (state != ST_IDLE);
    out_load   = 1'b0;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_PREP;
      ST_PREP:   state_next = ST_SCALE;
      ST_SCALE:  state_next = ST_DIV;
      ST_DIV:    if (div_cnt == '0) state_next = ST_ERR;
      ST_ERR:    state_next = ST_UPD;
      ST_UPD:    state_next = ST_MUL_P;
      ST_MUL_P:  state_next = ST_MUL_I;
      ST_MUL_I:  state_next = ST_MUL_D;
      ST_MUL_D:  state_next = ST_ACC;
      ST_ACC:    state_next = ST_ROUND;
      ST_ROUND:  state_next = ST_DUTY_L;
      ST_DUTY_L: state_next = ST_DUTY_R;
      ST_DUTY_R: state_next = ST_OUT;
      ST_OUT: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // weighted centroid terms and scan class
  assign ea     = $signed(WSUM_W'(sa));
  assign eb     = $signed(WSUM_W'(sb));
  assign ec     = $signed(WSUM_W'(sc));
  assign ed     = $signed(WSUM_W'(sd));
  assign wsum_c = (ea <<< 1) + ea + eb - ec - (ed <<< 1) - ed;
  assign sum_c  = SUM_W'(sa) + SUM_W'(sb) + SUM_W'(sc) + SUM_W'(sd);
  assign lit_c  = (sa > dark_level) | (sb > dark_level) | (sc > dark_level) |
                  (sd > dark_level);

  assign hi_a = sa > bright_level;
  assign hi_b = sb > bright_level;
  assign hi_c = sc > bright_level;
  assign hi_d = sd > bright_level;
  assign lo_a = sa < bright_level;
  assign lo_b = sb < bright_level;
  assign lo_c = sc < bright_level;
  assign lo_d = sd < bright_level;

  always_comb begin
    if (hi_a && hi_b && hi_c && hi_d) begin
      mnv_c = MNV_JUNCTION; lrev_c = 1'b1; rrev_c = 1'b0;
    end else if (hi_a && lo_d) begin
      mnv_c = MNV_LEFT;     lrev_c = 1'b1; rrev_c = 1'b0;
    end else if (lo_a && hi_d) begin
      mnv_c = MNV_RIGHT;    lrev_c = 1'b0; rrev_c = 1'b1;
    end else if (lo_a && lo_b && lo_c && lo_d) begin
      mnv_c = MNV_DARK;     lrev_c = 1'b0; rrev_c = 1'b1;
    end else if (lo_b && lo_c) begin
      mnv_c = MNV_BLIND;    lrev_c = 1'b0; rrev_c = 1'b0;
    end else begin
      mnv_c = MNV_STRAIGHT; lrev_c = 1'b0; rrev_c = 1'b0;
    end
  end

  // dividend: |wsum| * 10 << FRAC_BITS, plus half the divisor for rounding
  assign absw  = wneg ? SUM_W'(-wsum) : SUM_W'(wsum);
  assign abs10 = (ABS10_W'(absw) << 3) + (ABS10_W'(absw) << 1);
  assign dvd_c = (DVD_W'(abs10) << FRAC_BITS) + DVD_W'(sum >> 1);

  // one restoring divider step
  assign shifted = {rem, quo[Q_W-1]};
  assign div_ge  = shifted >= {1'b0, sum};
  assign trial   = shifted - {1'b0, sum};

  // error: rounded centroid, or the line-lost value
  assign qs = $signed({1'b0, quo});
  always_comb begin
    if (!lit) begin
      err_c = (last_error > 0) ? ERR_LOST : -ERR_LOST;
    end else if (sum == '0) begin
      err_c = '0;
    end else begin
      err_c = wneg ? -qs : qs;
    end
  end

  // integral update with clamp
  assign err_x  = $signed({err[ERR_W-1], err});
  assign last_x = $signed({last_error[ERR_W-1], last_error});
  assign esum_x = $signed({esum[ERR_W-1], esum});
  assign esum_t = esum_x + err_x;
  assign esum_c = (esum_t > ESUM_HI) ? ESUM_HI : ((esum_t < ESUM_LO) ? ESUM_LO : esum_t);

  // shared multiplier operand select
  always_comb begin
    case (state)
      ST_MUL_P: begin
        gain_sel = prop_gain;
        opnd     = err_x;
      end
      ST_MUL_I: begin
        gain_sel = integral_gain;
        opnd     = esum_x;
      end
      default: begin
        gain_sel = deriv_gain;
        opnd     = diff;
      end
    endcase
  end

  assign prod_c = $signed({1'b0, gain_sel}) * opnd;
  assign prod_x = $signed({{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod});

  // round the sum of products down by FRAC_BITS bits to the duty scale, ties away from zero
  assign acc_mag  = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
  assign acc_rnd  = acc_mag + RND_HALF;
  assign corr_pos = $signed({1'b0, acc_rnd[ACC_W-1:FRAC_BITS]});

  // duty around base, clamped to min then max; left subtracts, right adds
  assign base_s  = $signed({{(DUTY_W-DOUT_W){1'b0}}, base_duty, {FRAC_BITS{1'b0}}});
  assign lo_s    = $signed({{(DUTY_W-DOUT_W){1'b0}}, min_duty, {FRAC_BITS{1'b0}}});
  assign hi_s    = $signed({{(DUTY_W-DOUT_W){1'b0}}, max_duty, {FRAC_BITS{1'b0}}});
  assign corr_x  = $signed({corr[CORR_W-1], corr});
  assign duty_v  = base_s + ((state == ST_DUTY_L) ? -corr_x : corr_x);
  assign duty_c1 = (duty_v < lo_s) ? lo_s : duty_v;
  assign duty_c2 = (duty_c1 > hi_s) ? hi_s : duty_c1;

  // junction boost: floor of 1.5 times the duty
  assign junc_l = (mnv == MNV_JUNCTION) ?
                  JUNC_W'(left_val) + JUNC_W'(left_val >> 1) : JUNC_W'(left_val);
  assign junc_r = (mnv == MNV_JUNCTION) ?
                  JUNC_W'(right_val) + JUNC_W'(right_val >> 1) : JUNC_W'(right_val);

  // error history and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      last_error <= '0;
      esum       <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (state == ST_UPD) begin
        last_error <= err;
        esum       <= esum_c[ERR_W-1:0];
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          sa <= sensor_a;
          sb <= sensor_b;
          sc <= sensor_c;
          sd <= sensor_d;
        end
      end
      ST_PREP: begin
        wsum <= wsum_c;
        wneg <= wsum_c[WSUM_W-1];
        sum  <= sum_c;
        lit  <= lit_c;
        mnv  <= mnv_c;
        lrev <= lrev_c;
        rrev <= rrev_c;
      end
      ST_SCALE: begin
        rem     <= SUM_W'(dvd_c[DVD_W-1:Q_W]);
        quo     <= dvd_c[Q_W-1:0];
        div_cnt <= DIV_CNT_W'(Q_W - 1);
      end
      ST_DIV: begin
        rem     <= div_ge ? trial[SUM_W-1:0] : shifted[SUM_W-1:0];
        quo     <= {quo[Q_W-2:0], div_ge};
        div_cnt <= div_cnt - 1'b1;
      end
      ST_ERR:   err  <= err_c;
      ST_UPD:   diff <= err_x - last_x;
      ST_MUL_P: prod <= prod_c;
      ST_MUL_I: begin
        prod <= prod_c;
        acc  <= prod_x;
      end
      ST_MUL_D: begin
        prod <= prod_c;
        acc  <= acc + prod_x;
      end
      ST_ACC:    acc  <= acc + prod_x;
      ST_ROUND:  corr <= acc[ACC_W-1] ? -corr_pos : corr_pos;
      ST_DUTY_L: left_val  <= duty_c2[DOUT_W-1:0];
      ST_DUTY_R: right_val <= duty_c2[DOUT_W-1:0];
      ST_OUT: begin
        if (out_load) begin
          left_duty     <= OUT_W'(junc_l);
          right_duty    <= OUT_W'(junc_r);
          left_reverse  <= lrev;
          right_reverse <= rrev;
          manoeuvre     <= mnv;
        end
      end
      default: ;
    endcase
  end

  `LPD_CHECK_NEXT(a_accept_starts_prep, in_valid && !in_stall, state == ST_PREP, "accepted scan did not start the sequencer")
  `LPD_CHECK(a_esum_in_range, 1'b1, (esum <= ESUM_LIM) && (esum >= -ESUM_LIM), "integral left its clamp range")
  `LPD_CHECK(a_valid_from_out, $rose(out_valid), $past(state) == ST_OUT, "result raised outside the output step")
  `LPD_CHECK(a_div_count_range, state == ST_DIV, div_cnt < DIV_CNT_W'(Q_W), "divider step count out of range")

endmodule

// File: tb/line_position_pid_drive_unit_test.sv
module line_position_pid_drive_unit_test;
  import lpd_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int DRAIN_CYCLES  = 40;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_SCANS   = 155;
  localparam int HOLD_SCANS    = 60;
  localparam int HOLD_CYCLES   = 400;
  localparam int SENS_MAX      = (1 << SENS_W) - 1;

  typedef struct packed {
    logic [SENS_W-1:0] outer_left;
    logic [SENS_W-1:0] inner_left;
    logic [SENS_W-1:0] inner_right;
    logic [SENS_W-1:0] outer_right;
  } scan_t;

  typedef struct packed {
    logic [OUT_W-1:0] left_duty;
    logic [OUT_W-1:0] right_duty;
    logic             left_reverse;
    logic             right_reverse;
    mnv_t             manoeuvre;
  } drive_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [SENS_W-1:0] sensor_a = '0;
  logic [SENS_W-1:0] sensor_b = '0;
  logic [SENS_W-1:0] sensor_c = '0;
  logic [SENS_W-1:0] sensor_d = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [OUT_W-1:0]  left_duty;
  logic [OUT_W-1:0]  right_duty;
  logic              left_reverse;
  logic              right_reverse;
  logic [2:0]        manoeuvre;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  line_position_pid_drive_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sensor_a     (sensor_a),
    .sensor_b     (sensor_b),
    .sensor_c     (sensor_c),
    .sensor_d     (sensor_d),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .left_duty    (left_duty),
    .right_duty   (right_duty),
    .left_reverse (left_reverse),
    .right_reverse(right_reverse),
    .manoeuvre    (manoeuvre),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #5 clk = ~clk;

  // Register shadow, kept in step with every write
  logic [GAIN_W-1:0] cfg_prop_gain     = '0;
  logic [GAIN_W-1:0] cfg_integral_gain = '0;
  logic [GAIN_W-1:0] cfg_deriv_gain    = '0;
  logic [DCFG_W-1:0] cfg_base_duty     = BASE_RST;
  logic [DCFG_W-1:0] cfg_min_duty      = MIN_RST;
  logic [DCFG_W-1:0] cfg_max_duty      = MAX_RST;
  logic [SENS_W-1:0] cfg_dark_level    = DARK_RST;
  logic [SENS_W-1:0] cfg_bright_level  = BRIGHT_RST;

  // Steering history of the predictor
  longint heading_error_prev = 0;
  longint heading_error_sum  = 0;

  drive_t expected_drive[$];
  int     fail_count   = 0;
  int     drive_beats  = 0;
  int     burst_left   = 0;
  bit     offering     = 1'b0;
  int     hold_request = 0;
  int unsigned cycle_count = 0;

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("ERROR: %s", msg);
  endfunction

  function automatic longint clamp_duty(input longint duty);
    longint lo;
    longint hi;
    lo = cfg_min_duty;
    hi = cfg_max_duty;
    lo = lo << FRAC_BITS;
    hi = hi << FRAC_BITS;
    if (duty < lo) duty = lo;
    if (duty > hi) duty = hi;
    return duty;
  endfunction

  // Work out the drive beat for one scan and advance the steering history
  function automatic drive_t predict_drive(input scan_t scan);
    longint rd [4];
    longint unit, dark, bright, weighted, total, err, diff, q, mag, acc, corr;
    longint kp, ki, kd, base, left, right;
    logic   lit;
    logic [3:0] above, below;
    drive_t d;
    unit   = longint'(1) << FRAC_BITS;
    dark   = cfg_dark_level;
    bright = cfg_bright_level;
    kp     = cfg_prop_gain;
    ki     = cfg_integral_gain;
    kd     = cfg_deriv_gain;
    base   = cfg_base_duty;
    rd[0]  = scan.outer_left;
    rd[1]  = scan.inner_left;
    rd[2]  = scan.inner_right;
    rd[3]  = scan.outer_right;
    lit    = 1'b0;
    total  = 0;
    for (int i = 0; i < 4; i++) begin
      if (rd[i] > dark) lit = 1'b1;
      total += rd[i];
      above[i] = rd[i] > bright;
      below[i] = rd[i] < bright;
    end
    weighted = 3 * rd[0] + rd[1] - rd[2] - 3 * rd[3];

    // Centroid error, or a fixed swing toward the side the line was last seen
    if (!lit) begin
      err = (heading_error_prev > 0) ? 25 * unit : -25 * unit;
    end else if (total != 0) begin
      mag = weighted * 10 * unit;
      q = ((mag < 0 ? -mag : mag) + total / 2) / total;
      err = (mag < 0) ? -q : q;
    end else begin
      err = 0;
    end

    diff = err - heading_error_prev;
    heading_error_sum += err;
    if (heading_error_sum > 30 * unit) heading_error_sum = 30 * unit;
    if (heading_error_sum < -30 * unit) heading_error_sum = -30 * unit;

    // PID sum, rounded half away from zero on the way down
    acc  = kp * err + ki * heading_error_sum + kd * diff;
    mag  = (acc < 0) ? -acc : acc;
    corr = (mag + unit / 2) >> FRAC_BITS;
    if (acc < 0) corr = -corr;
    heading_error_prev = err;

    left  = clamp_duty(base * unit - corr);
    right = clamp_duty(base * unit + corr);

    d.left_reverse  = 1'b0;
    d.right_reverse = 1'b0;
    d.manoeuvre     = MNV_STRAIGHT;
    if (&above) begin
      d.manoeuvre    = MNV_JUNCTION;
      d.left_reverse = 1'b1;
      left  = (3 * left) >> 1;
      right = (3 * right) >> 1;
    end else if (above[0] && below[3]) begin
      d.manoeuvre    = MNV_LEFT;
      d.left_reverse = 1'b1;
    end else if (below[0] && above[3]) begin
      d.manoeuvre     = MNV_RIGHT;
      d.right_reverse = 1'b1;
    end else if (&below) begin
      d.manoeuvre     = MNV_DARK;
      d.right_reverse = 1'b1;
    end else if (below[1] && below[2]) begin
      d.manoeuvre = MNV_BLIND;
    end
    d.left_duty  = OUT_W'(left);
    d.right_duty = OUT_W'(right);
    return d;
  endfunction

  function automatic scan_t make_scan(input int a, input int b, input int c, input int d);
    scan_t s;
    s.outer_left  = SENS_W'(a);
    s.inner_left  = SENS_W'(b);
    s.inner_right = SENS_W'(c);
    s.outer_right = SENS_W'(d);
    return s;
  endfunction

  // Reading above, below or equal to a level, as far as the range allows
  function automatic int reading_near(input int level, input int side);
    if (side > 0) return (level < SENS_MAX) ? $urandom_range(SENS_MAX, level + 1) : SENS_MAX;
    if (side < 0) return (level > 0) ? $urandom_range(level - 1, 0) : 0;
    return level;
  endfunction

  function automatic scan_t random_scan();
    int rd [4];
    int pos;
    int side;
    for (int i = 0; i < 4; i++) rd[i] = 0;
    case ($urandom_range(0, 9))
      0, 1: begin
        for (int i = 0; i < 4; i++) rd[i] = $urandom_range(0, SENS_MAX);
      end
      2: begin
        for (int i = 0; i < 4; i++) rd[i] = $urandom_range(0, int'(cfg_dark_level));
      end
      3, 4, 5: begin
        // Each sensor above, below or at the classification level
        for (int i = 0; i < 4; i++) begin
          side = $urandom_range(0, 4);
          rd[i] = reading_near(int'(cfg_bright_level), side < 2 ? 1 : (side < 4 ? -1 : 0));
        end
      end
      6: begin
        for (int i = 0; i < 4; i++) begin
          case ($urandom_range(0, 5))
            0: rd[i] = 0;
            1: rd[i] = SENS_MAX;
            2: rd[i] = cfg_dark_level;
            3: rd[i] = cfg_bright_level;
            4: rd[i] = reading_near(int'(cfg_bright_level), 1);
            default: rd[i] = reading_near(int'(cfg_dark_level), -1);
          endcase
        end
      end
      7: begin
        for (int i = 0; i < 4; i++) rd[i] = $urandom_range(0, 15);
      end
      default: begin
        // Line under one sensor, maybe spilling onto a neighbor
        pos = $urandom_range(0, 3);
        for (int i = 0; i < 4; i++) begin
          if (i == pos) rd[i] = $urandom_range(2500, SENS_MAX);
          else if ((i == pos - 1 || i == pos + 1) && $urandom_range(0, 1))
            rd[i] = $urandom_range(500, 2500);
          else rd[i] = $urandom_range(0, 400);
        end
      end
    endcase
    return make_scan(rd[0], rd[1], rd[2], rd[3]);
  endfunction

  // Offer one scan, in bursts with gaps between them
  task automatic send_scan(input scan_t scan);
    if (burst_left == 0) begin
      if (offering) begin
        in_valid <= 1'b0;
        offering = 1'b0;
      end
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 16);
    end
    in_valid <= 1'b1;
    offering = 1'b1;
    sensor_a <= scan.outer_left;
    sensor_b <= scan.inner_left;
    sensor_c <= scan.inner_right;
    sensor_d <= scan.outer_right;
    do @(posedge clk); while (in_stall);
    expected_drive.push_back(predict_drive(scan));
    burst_left--;
  endtask

  task automatic drop_scans();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
    burst_left = 0;
  endtask

  task automatic wait_drained();
    drop_scans();
    while (expected_drive.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Write one register, read it back, and update the shadow
  task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== value)
      note_failure($sformatf("register %s read back %0h, written %0h", idx.name(), prdata, value));
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_PROP_GAIN:     cfg_prop_gain     = value[GAIN_W-1:0];
      REG_INTEGRAL_GAIN: cfg_integral_gain = value[GAIN_W-1:0];
      REG_DERIV_GAIN:    cfg_deriv_gain    = value[GAIN_W-1:0];
      REG_BASE_DUTY:     cfg_base_duty     = value[DCFG_W-1:0];
      REG_MIN_DUTY:      cfg_min_duty      = value[DCFG_W-1:0];
      REG_MAX_DUTY:      cfg_max_duty      = value[DCFG_W-1:0];
      REG_DARK_LEVEL:    cfg_dark_level    = value[SENS_W-1:0];
      REG_BRIGHT_LEVEL:  cfg_bright_level  = value[SENS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_setup(input int kp, input int ki, input int kd, input int base,
                            input int lo, input int hi, input int dark, input int bright);
    write_reg(REG_PROP_GAIN, kp);
    write_reg(REG_INTEGRAL_GAIN, ki);
    write_reg(REG_DERIV_GAIN, kd);
    write_reg(REG_BASE_DUTY, base);
    write_reg(REG_MIN_DUTY, lo);
    write_reg(REG_MAX_DUTY, hi);
    write_reg(REG_DARK_LEVEL, dark);
    write_reg(REG_BRIGHT_LEVEL, bright);
  endtask

  function automatic int random_gain();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return (1 << GAIN_W) - 1;
      2: return $urandom_range(0, 255);
      3, 4: return $urandom_range(0, 2047);
      default: return $urandom_range(0, (1 << GAIN_W) - 1);
    endcase
  endfunction

  task automatic load_random_setup();
    int base, lo, hi, dark, bright;
    if ($urandom_range(0, 3) == 0) begin
      base = $urandom_range(0, 100);
      lo   = $urandom_range(0, 100);
      hi   = $urandom_range(0, 100);
    end else begin
      lo   = $urandom_range(0, 50);
      hi   = $urandom_range(50, 100);
      base = $urandom_range(lo, hi);
    end
    case ($urandom_range(0, 7))
      0: dark = 0;
      1: dark = SENS_MAX;
      default: dark = $urandom_range(0, 1200);
    endcase
    case ($urandom_range(0, 7))
      0: bright = 0;
      1: bright = SENS_MAX;
      default: bright = $urandom_range(800, 3500);
    endcase
    load_setup(random_gain(), random_gain(), random_gain(), base, lo, hi, dark, bright);
  endtask

  // Receiver: stall on a changing pattern, or hold off when asked
  always @(posedge clk) begin : drive_sink
    stall_mode_t stall_mode;
    int stall_tick;
    int hold_left;
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (stall_tick <= 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_tick = $urandom_range(20, 120);
    end
    stall_tick--;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= ((stall_tick % 5) < 2);
      endcase
    end
  end

  // Compare each drive beat with the oldest prediction
  always @(posedge clk) begin : drive_check
    drive_t want;
    if (!rst && out_valid && !out_stall) begin
      drive_beats++;
      if (expected_drive.size() == 0) begin
        note_failure($sformatf("drive beat %0d with nothing pending: left %0d right %0d mnv %0d",
                               drive_beats, left_duty, right_duty, manoeuvre));
      end else begin
        want = expected_drive.pop_front();
        if (left_duty !== want.left_duty || right_duty !== want.right_duty ||
            left_reverse !== want.left_reverse || right_reverse !== want.right_reverse ||
            manoeuvre !== want.manoeuvre)
          note_failure($sformatf({"drive beat %0d (got/want): left %0d/%0d right %0d/%0d ",
                                  "lrev %0b/%0b rrev %0b/%0b mnv %0d/%0d"}, drive_beats,
                                 left_duty, want.left_duty, right_duty, want.right_duty,
                                 left_reverse, want.left_reverse, right_reverse,
                                 want.right_reverse, manoeuvre, want.manoeuvre));
      end
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // Scans under the register defaults: zero gains leave the base duty, boosted on a junction
  task automatic test_reset_defaults();
    send_scan(make_scan(1000, 1000, 1000, 1000));
    send_scan(make_scan(4095, 4095, 4095, 4095));
    send_scan(make_scan(2500, 0, 0, 0));
    wait_drained();
  endtask

  // Every register at zero and at a high value; gains and levels at the top of their range
  task automatic test_register_readback();
    load_setup(65535, 65535, 65535, 100, 100, 100, 4095, 4095);
    load_setup(0, 0, 0, 0, 0, 0, 0, 0);
  endtask

  // Scans for every manoeuvre, plus line-lost recovery in both directions
  task automatic test_manoeuvre_classes();
    load_setup(512, 64, 128, 49, 39, 59, 400, 2000);
    send_scan(make_scan(4095, 4095, 4095, 4095));
    send_scan(make_scan(3000, 100, 100, 100));
    send_scan(make_scan(100, 1000, 1000, 3000));
    send_scan(make_scan(1000, 1000, 1000, 1000));
    send_scan(make_scan(2000, 100, 100, 2000));
    send_scan(make_scan(2000, 3000, 3000, 2000));
    send_scan(make_scan(2000, 2000, 2000, 2000));
    send_scan(make_scan(3000, 500, 0, 0));
    send_scan(make_scan(100, 100, 100, 100));
    send_scan(make_scan(0, 0, 500, 3000));
    send_scan(make_scan(0, 0, 0, 0));
    send_scan(make_scan(4095, 0, 0, 4095));
    send_scan(make_scan('hAAA, 'h555, 'hAAA, 'h555));
    send_scan(make_scan(400, 400, 400, 400));
    wait_drained();
  endtask

  // Saturating gains, crossed duty limits and threshold extremes
  task automatic test_setting_extremes();
    load_setup(65535, 65535, 65535, 100, 0, 100, 400, 2000);
    send_scan(make_scan(4095, 0, 0, 0));
    send_scan(make_scan(0, 0, 0, 4095));
    send_scan(make_scan(4095, 4095, 4095, 4095));
    wait_drained();
    load_setup(300, 20, 600, 50, 80, 20, 400, 2000);
    send_scan(make_scan(3000, 200, 0, 0));
    send_scan(make_scan(0, 200, 1500, 100));
    wait_drained();
    load_setup(0, 0, 0, 0, 0, 0, 4095, 0);
    send_scan(make_scan(4095, 4095, 4095, 4095));
    send_scan(make_scan(0, 0, 0, 0));
    wait_drained();
    load_setup(1024, 512, 2048, 70, 10, 100, 0, 4095);
    send_scan(make_scan(1, 0, 0, 0));
    send_scan(make_scan(4095, 4095, 0, 4095));
    wait_drained();
  endtask

  // Random scans under a series of random register settings
  task automatic test_random_scans();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      load_random_setup();
      for (int n = 0; n < PHASE_SCANS; n++) send_scan(random_scan());
      wait_drained();
    end
  endtask

  // Hold the drive side off long enough for the block to back up its input
  task automatic test_output_hold();
    load_setup(640, 96, 320, 55, 30, 80, 350, 1800);
    hold_request = HOLD_CYCLES;
    for (int n = 0; n < HOLD_SCANS; n++) send_scan(random_scan());
    wait_drained();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_register_readback();
    test_manoeuvre_classes();
    test_setting_extremes();
    test_output_hold();
    test_random_scans();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/lpd_pkg.sv
hw/rtl/line_position_pid_drive_unit.sv
tb/line_position_pid_drive_unit_test.sv
